>>> design/slc_norm_pkg.sv
// types and constants shared by the slice index normalizer
package slc_norm_pkg;

  localparam int IndexWidth = 32;
  localparam int LenWidth   = 31;

  localparam logic [LenWidth-1:0] MaxStepMag = {LenWidth{1'b1}};

  typedef enum logic [0:0] {
    STATUS_OK        = 1'b0,
    STATUS_STEP_ZERO = 1'b1
  } status_e;

  typedef struct packed {
    logic signed [IndexWidth-1:0] start_in;
    logic signed [IndexWidth-1:0] stop_in;
    logic signed [IndexWidth-1:0] step_in;
    logic                         start_given;
    logic                         stop_given;
    logic                         step_given;
    logic        [LenWidth-1:0]   seq_length;
  } in_item_t;

  typedef struct packed {
    logic signed [IndexWidth-1:0] start_out;
    logic signed [IndexWidth-1:0] stop_out;
    logic        [LenWidth-1:0]   step_mag;
    logic        [LenWidth-1:0]   count;
    status_e                      status;
  } out_item_t;

endpackage

>>> design/slice_index_normalizer_top.sv
// slice index normalizer: bound wrap and clamp, then a pipelined restoring divider
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o   | in_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_o (out_item_t)
//
// one transaction per cycle while the skid register is empty
// pipeline: decode, clamp and distance stages, one divider stage per quotient bit
// (31), then the output register
// reset clears every valid bit, the skid valid bit among them; payload registers are not reset
// a skid register catches one result while the output is stalled; the whole pipeline
// then holds until the skid register drains
module slice_index_normalizer_top
  import slc_norm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  localparam int IW = IndexWidth;
  localparam int LW = LenWidth;

  typedef struct packed {
    logic                 zero;
    logic                 fwd;
    logic        [IW-1:0] mag;
    logic signed [IW-1:0] lower;
    logic signed [IW-1:0] upper;
    logic                 start_given;
    logic                 stop_given;
    logic signed [IW-1:0] start_raw;
    logic signed [IW-1:0] stop_raw;
    logic signed [IW:0]   start_wrap;
    logic signed [IW:0]   stop_wrap;
  } dec_t;

  typedef struct packed {
    logic                 zero;
    logic                 fwd;
    logic        [IW-1:0] mag;
    logic signed [IW-1:0] s;
    logic signed [IW-1:0] e;
  } clamp_t;

  typedef struct packed {
    logic                 zero;
    logic                 nonempty;
    logic        [IW-1:0] mag;
    logic signed [IW-1:0] s;
    logic signed [IW-1:0] e;
    logic        [LW-1:0] dividend;
    logic        [IW-1:0] rem;
    logic        [LW-1:0] quo;
  } div_t;

  logic      en;
  logic      a_v_q, b_v_q, c_v_q;
  dec_t      a_d, a_q;
  clamp_t    b_d, b_q;
  div_t      c_d, c_q;
  logic      [LW-1:0] dv_q;
  div_t      div_d [LW];
  div_t      div_q [LW];
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q, res;
  logic      pop;

  function automatic logic signed [IW-1:0] clamp_bound(
    input logic signed [IW-1:0] raw,
    input logic signed [IW:0]   wrap,
    input logic signed [IW-1:0] lower,
    input logic signed [IW-1:0] upper
  );
    logic signed [IW:0] lower_x;
    lower_x = {lower[IW-1], lower};
    if (raw[IW-1]) begin
      clamp_bound = (wrap < lower_x) ? lower : wrap[IW-1:0];
    end else begin
      clamp_bound = (raw > upper) ? upper : raw;
    end
  endfunction

  assign en         = ~skid_valid_q;
  assign in_ready_o = en;
  assign pop        = out_valid_q & out_ready_i;

  // decode step and wrap negative bounds
  always_comb begin
    logic signed [IW-1:0] step_eff;
    logic signed [IW-1:0] len_x;
    step_eff = in_i.step_given ? in_i.step_in : IW'(1);
    len_x    = $signed({{(IW-LW){1'b0}}, in_i.seq_length});
    a_d.zero        = (step_eff == '0);
    a_d.fwd         = ~step_eff[IW-1];
    a_d.mag         = step_eff[IW-1] ? IW'(-step_eff) : IW'(step_eff);
    a_d.lower       = step_eff[IW-1] ? '1 : '0;
    a_d.upper       = step_eff[IW-1] ? len_x - IW'(1) : len_x;
    a_d.start_given = in_i.start_given;
    a_d.stop_given  = in_i.stop_given;
    a_d.start_raw   = in_i.start_in;
    a_d.stop_raw    = in_i.stop_in;
    a_d.start_wrap  = {in_i.start_in[IW-1], in_i.start_in} + {1'b0, len_x};
    a_d.stop_wrap   = {in_i.stop_in[IW-1], in_i.stop_in} + {1'b0, len_x};
  end

  // clamp and default the bounds
  always_comb begin
    b_d.zero = a_q.zero;
    b_d.fwd  = a_q.fwd;
    b_d.mag  = a_q.mag;
    if (a_q.start_given) begin
      b_d.s = clamp_bound(a_q.start_raw, a_q.start_wrap, a_q.lower, a_q.upper);
    end else begin
      b_d.s = a_q.fwd ? a_q.lower : a_q.upper;
    end
    if (a_q.stop_given) begin
      b_d.e = clamp_bound(a_q.stop_raw, a_q.stop_wrap, a_q.lower, a_q.upper);
    end else begin
      b_d.e = a_q.fwd ? a_q.upper : a_q.lower;
    end
  end

  // distance minus one, the divider's dividend
  always_comb begin
    logic signed [IW:0] s_x;
    logic signed [IW:0] e_x;
    logic signed [IW:0] dm1;
    s_x = {b_q.s[IW-1], b_q.s};
    e_x = {b_q.e[IW-1], b_q.e};
    dm1 = b_q.fwd ? (e_x + ~s_x) : (s_x + ~e_x);
    c_d.zero     = b_q.zero;
    c_d.nonempty = ~dm1[IW];
    c_d.mag      = b_q.mag;
    c_d.s        = b_q.s;
    c_d.e        = b_q.e;
    c_d.dividend = dm1[LW-1:0];
    c_d.rem      = '0;
    c_d.quo      = '0;
  end

  // one restoring quotient bit per stage, msb first
  for (genvar k = 0; k < LW; k++) begin : g_div
    div_t src;
    logic [IW:0] trial;
    logic [IW:0] diff;
    logic        ge;
    assign src   = (k == 0) ? c_q : div_q[(k == 0) ? 0 : k-1];
    assign trial = {src.rem, src.dividend[LW-1-k]};
    assign diff  = trial - {1'b0, src.mag};
    assign ge    = (trial >= {1'b0, src.mag});
    always_comb begin
      div_d[k]     = src;
      div_d[k].rem = ge ? diff[IW-1:0] : trial[IW-1:0];
      div_d[k].quo = {src.quo[LW-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      dv_q  <= '0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      dv_q  <= {dv_q[LW-2:0], c_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  // result assembly from the last divider stage
  always_comb begin
    div_t last;
    last = div_q[LW-1];
    if (last.zero) begin
      res = '{start_out: '0, stop_out: '0, step_mag: '0, count: '0,
              status: STATUS_STEP_ZERO};
    end else begin
      res.start_out = last.s;
      res.stop_out  = last.e;
      res.step_mag  = (last.mag > IW'(MaxStepMag)) ? MaxStepMag : last.mag[LW-1:0];
      res.count     = last.nonempty ? last.quo + LW'(1) : '0;
      res.status    = STATUS_OK;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_valid_q || pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= dv_q[LW-1];
    end else if (dv_q[LW-1]) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_valid_q || pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid entry filled without an output stall");

  a_zero_step_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == STATUS_STEP_ZERO) |->
      (out_o.count == '0 && out_o.step_mag == '0))
    else $error("zero step transaction carries nonzero fields");

  a_ok_step_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == STATUS_OK) |-> (out_o.step_mag != '0))
    else $error("valid step with zero magnitude");

  a_count_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == STATUS_OK && out_o.count != '0) |->
      (out_o.start_out != out_o.stop_out))
    else $error("nonzero count over an empty span");

endmodule
